// ===== hw/rtl/fsa_pkg.sv =====
`timescale 1ns / 1ps
package fsa_pkg;

	localparam int CoordWidth   = 24;
	localparam int DiffWidth    = CoordWidth + 1;
	localparam int RadiusWidth  = 23;
	localparam int GainWidth    = 16;
	localparam int CountWidth   = 9;
	localparam int SumWidth     = 24;
	localparam int AccelWidth   = 25;
	localparam int UnitWidth    = 16;
	localparam int TermWidth    = 32;
	localparam int MaxNeighbors = 256;

	localparam int DivNumWidth  = 40;
	localparam int DivDenWidth  = 25;
	localparam int DivSteps     = 40;
	localparam int SqrtInWidth  = 50;
	localparam int SqrtOutWidth = 25;
	localparam int SqrtSteps    = 25;

	localparam logic [2:0] REG_SEP_RADIUS    = 3'd0;
	localparam logic [2:0] REG_ALIGN_RADIUS  = 3'd1;
	localparam logic [2:0] REG_COHERE_RADIUS = 3'd2;
	localparam logic [2:0] REG_SEP_GAIN      = 3'd3;
	localparam logic [2:0] REG_ALIGN_GAIN    = 3'd4;
	localparam logic [2:0] REG_COHERE_GAIN   = 3'd5;

	localparam logic [1:0] BAND_SEP = 2'd0;
	localparam logic [1:0] BAND_ALN = 2'd1;
	localparam logic [1:0] BAND_COH = 2'd2;

	localparam logic CMD_SELF     = 1'b0;
	localparam logic CMD_NEIGHBOR = 1'b1;

	function automatic logic [DiffWidth-1:0] mag(input logic signed [DiffWidth-1:0] v);
		mag = v[DiffWidth-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ===== hw/rtl/fsa_item_if.sv =====
`timescale 1ns / 1ps
interface fsa_item_if;
	import fsa_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [CoordWidth-1:0] pos_x;
	logic signed [CoordWidth-1:0] pos_y;
	logic signed [CoordWidth-1:0] pos_z;
	logic signed [CoordWidth-1:0] vel_x;
	logic signed [CoordWidth-1:0] vel_y;
	logic signed [CoordWidth-1:0] vel_z;
	logic                         last;
	modport source (output valid, command, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, last,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, last,
		output ready);
endinterface

// ===== hw/rtl/fsa_result_if.sv =====
`timescale 1ns / 1ps
interface fsa_result_if;
	import fsa_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [AccelWidth-1:0] accel_x;
	logic signed [AccelWidth-1:0] accel_y;
	logic signed [AccelWidth-1:0] accel_z;
	logic                         sep_only;
	modport source (output valid, accel_x, accel_y, accel_z, sep_only, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, sep_only, output ready);
endinterface

// ===== hw/rtl/fsa_cfg_if.sv =====
`timescale 1ns / 1ps
interface fsa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [22:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fsa_div.sv =====
`timescale 1ns / 1ps
module fsa_div
	import fsa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [DivNumWidth-1:0] num,
	input  logic [DivDenWidth-1:0] den,
	output logic                   done,
	output logic [DivNumWidth-1:0] quo
);
	logic [DivNumWidth-1:0] num_q;
	logic [DivNumWidth-1:0] quo_q;
	logic [DivDenWidth-1:0] den_q;
	logic [DivDenWidth-1:0] rem_q;
	logic [5:0]             cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DivDenWidth:0]   rem_n;
	logic [DivDenWidth:0]   diff;

	// One quotient bit per cycle, restoring form.
	assign rem_n = {rem_q, num_q[DivNumWidth-1]};
	assign diff  = rem_n - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DivNumWidth-2:0], 1'b0};
			if (!diff[DivDenWidth]) begin
				rem_q <= diff[DivDenWidth-1:0];
				quo_q <= {quo_q[DivNumWidth-2:0], 1'b1};
			end else begin
				rem_q <= rem_n[DivDenWidth-1:0];
				quo_q <= {quo_q[DivNumWidth-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== hw/rtl/fsa_sqrt.sv =====
`timescale 1ns / 1ps
module fsa_sqrt
	import fsa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [SqrtInWidth-1:0]  radicand,
	output logic                    done,
	output logic [SqrtOutWidth-1:0] root
);
	logic [SqrtInWidth-1:0]  rad_q;
	logic [SqrtOutWidth-1:0] root_q;
	logic [27:0]             rem_q;
	logic [4:0]              cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [27:0]             rem_n;
	logic [27:0]             trial;

	// Two radicand bits per cycle yield one root bit.
	assign rem_n = {rem_q[25:0], rad_q[SqrtInWidth-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(SqrtSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SqrtInWidth-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[SqrtOutWidth-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[SqrtOutWidth-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== hw/rtl/flocking_steering_accumulator.sv =====
`timescale 1ns / 1ps
// A self item is stored from the idle state, and averaging follows when it also closes the list.
// A neighbor is first squared on the shared multiplier, then each unit vector it needs
// takes a 25-step square root and three 40-step divisions.
// Closing an item adds nine averaging divisions; one item is in work at a time.
// Reset clears the focal agent, sums, counts and output valid, and loads default radii/gains.
module flocking_steering_accumulator
	import fsa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	fsa_item_if.sink     item,
	fsa_result_if.source result,
	fsa_cfg_if.sink      cfg
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_BAND, ST_SQRT, ST_DIV, ST_UPD,
		ST_TMUL, ST_TDIV, ST_EMIT
	} state_t;

	state_t state_q;

	logic [RadiusWidth-1:0]       radius_q [3];
	logic [GainWidth-1:0]         gain_q [3];
	logic signed [CoordWidth-1:0] self_pos_q [3];
	logic signed [CoordWidth-1:0] self_vel_q [3];
	logic signed [SumWidth-1:0]   sum_q [3][3];
	logic [CountWidth-1:0]        cnt_q [3];
	logic signed [DiffWidth-1:0]  dp_q [3];
	logic signed [DiffWidth-1:0]  dv_q [3];
	logic signed [UnitWidth-1:0]  u_q [3];
	logic signed [TermWidth-1:0]  term_q [3][3];
	logic [47:0]                  d2_q;
	logic [SqrtInWidth-1:0]       v2_q;
	logic [45:0]                  r2_q [3];
	logic [49:0]                  prod_q;
	logic [3:0]                   idx_q;
	logic [1:0]                   comp_q;
	logic [1:0]                   band_q;
	logic                         last_q;
	logic                         vec_sel_q;
	logic                         in_sep_q, in_aln_q, in_coh_q;
	logic [SqrtOutWidth-1:0]      len_q;

	logic                   div_go_q;
	logic [DivNumWidth-1:0] div_num_q;
	logic [DivDenWidth-1:0] div_den_q;
	logic                   div_done;
	logic [DivNumWidth-1:0] div_quo;
	logic                   sqrt_go_q;
	logic [SqrtInWidth-1:0] sqrt_rad_q;
	logic                   sqrt_done;
	logic [SqrtOutWidth-1:0] sqrt_root;

	logic                         out_valid_q;
	logic signed [AccelWidth-1:0] out_acc_q [3];
	logic                         out_sep_q;

	logic [DiffWidth-1:0]  mul_a, mul_b;
	logic [49:0]           prod_w;
	logic [DiffWidth-1:0]  unit_mag;
	logic [DiffWidth-1:0]  unit_mag_nx;
	logic [1:0]            comp_nx;
	logic                  far;
	logic [47:0]           r2e [3];
	logic signed [DiffWidth-1:0] pos_in [3];
	logic signed [DiffWidth-1:0] vel_in [3];
	logic signed [DiffWidth-1:0] sum_ext;
	logic [30:0]           tmag;
	logic signed [TermWidth-1:0] term_w;
	logic                  nz;
	logic signed [33:0]    acc_sum [3];
	logic signed [AccelWidth-1:0] acc_sat [3];

	fsa_div u_div (
		.clk (clk), .arst_n (arst_n), .go (div_go_q), .num (div_num_q), .den (div_den_q),
		.done (div_done), .quo (div_quo)
	);

	fsa_sqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .go (sqrt_go_q), .radicand (sqrt_rad_q),
		.done (sqrt_done), .root (sqrt_root)
	);

	assign item.ready      = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign result.valid    = out_valid_q;
	assign result.accel_x  = out_acc_q[0];
	assign result.accel_y  = out_acc_q[1];
	assign result.accel_z  = out_acc_q[2];
	assign result.sep_only = out_sep_q;

	assign pos_in[0] = DiffWidth'(item.pos_x);
	assign pos_in[1] = DiffWidth'(item.pos_y);
	assign pos_in[2] = DiffWidth'(item.pos_z);
	assign vel_in[0] = DiffWidth'(item.vel_x);
	assign vel_in[1] = DiffWidth'(item.vel_y);
	assign vel_in[2] = DiffWidth'(item.vel_z);

	// The one multiplier: squares while banding, sum times gain while averaging.
	assign sum_ext = DiffWidth'(sum_q[band_q][comp_q]);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_TMUL) begin
			mul_a = mag(sum_ext);
			mul_b = DiffWidth'(gain_q[band_q]);
		end else begin
			unique case (idx_q)
				4'd0, 4'd1, 4'd2: begin
					mul_a = mag(dp_q[idx_q[1:0]]);
					mul_b = mul_a;
				end
				4'd3: begin
					mul_a = DiffWidth'(radius_q[0]);
					mul_b = mul_a;
				end
				4'd4: begin
					mul_a = DiffWidth'(radius_q[1]);
					mul_b = mul_a;
				end
				4'd5: begin
					mul_a = DiffWidth'(radius_q[2]);
					mul_b = mul_a;
				end
				4'd6: begin
					mul_a = mag(dv_q[0]);
					mul_b = mul_a;
				end
				4'd7: begin
					mul_a = mag(dv_q[1]);
					mul_b = mul_a;
				end
				4'd8: begin
					mul_a = mag(dv_q[2]);
					mul_b = mul_a;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end
	assign prod_w = mul_a * mul_b;

	assign comp_nx     = comp_q + 2'd1;
	assign unit_mag    = vec_sel_q ? mag(dv_q[comp_q]) : mag(dp_q[comp_q]);
	assign unit_mag_nx = vec_sel_q ? mag(dv_q[comp_nx]) : mag(dp_q[comp_nx]);

	always_comb begin
		far = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (mag(dp_q[i]) >= DiffWidth'(1 << 23))
				far = 1'b1;
			r2e[i] = {2'b00, r2_q[i]};
		end
	end

	assign tmag   = div_quo[30:0];
	assign term_w = (cnt_q[band_q] == '0) ? '0 :
		(sum_q[band_q][comp_q] < 0 ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag}));

	always_comb begin
		nz = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (term_q[BAND_SEP][i] != '0)
				nz = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			if (nz)
				acc_sum[i] = 34'(term_q[BAND_SEP][i]);
			else
				acc_sum[i] = 34'(term_q[BAND_SEP][i]) + 34'(term_q[BAND_ALN][i])
					+ 34'(term_q[BAND_COH][i]);
			if (acc_sum[i] > 34'sd16777215)
				acc_sat[i] = 25'sd16777215;
			else if (acc_sum[i] < -34'sd16777216)
				acc_sat[i] = -25'sd16777216;
			else
				acc_sat[i] = acc_sum[i][AccelWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q[0] <= 23'd256;
			radius_q[1] <= 23'd1024;
			radius_q[2] <= 23'd4096;
			gain_q[0]   <= 16'd256;
			gain_q[1]   <= 16'd256;
			gain_q[2]   <= 16'd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SEP_RADIUS:    radius_q[0] <= cfg.data;
				REG_ALIGN_RADIUS:  radius_q[1] <= cfg.data;
				REG_COHERE_RADIUS: radius_q[2] <= cfg.data;
				REG_SEP_GAIN:      gain_q[0]   <= cfg.data[GainWidth-1:0];
				REG_ALIGN_GAIN:    gain_q[1]   <= cfg.data[GainWidth-1:0];
				REG_COHERE_GAIN:   gain_q[2]   <= cfg.data[GainWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				self_pos_q[i] <= '0;
				self_vel_q[i] <= '0;
				cnt_q[i]      <= '0;
				for (int j = 0; j < 3; j++)
					sum_q[i][j] <= '0;
			end
		end else begin
			div_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						last_q <= item.last;
						comp_q <= '0;
						band_q <= '0;
						if (item.command == CMD_SELF) begin
							self_pos_q[0] <= item.pos_x;
							self_pos_q[1] <= item.pos_y;
							self_pos_q[2] <= item.pos_z;
							self_vel_q[0] <= item.vel_x;
							self_vel_q[1] <= item.vel_y;
							self_vel_q[2] <= item.vel_z;
							for (int i = 0; i < 3; i++) begin
								cnt_q[i] <= '0;
								for (int j = 0; j < 3; j++)
									sum_q[i][j] <= '0;
							end
							if (item.last)
								state_q <= ST_TMUL;
						end else begin
							for (int i = 0; i < 3; i++) begin
								dp_q[i] <= pos_in[i] - DiffWidth'(self_pos_q[i]);
								dv_q[i] <= vel_in[i] - DiffWidth'(self_vel_q[i]);
							end
							d2_q    <= '0;
							v2_q    <= '0;
							idx_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= prod_w;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					unique case (idx_q)
						4'd0, 4'd1, 4'd2: d2_q <= d2_q + prod_q[47:0];
						4'd3: r2_q[0] <= prod_q[45:0];
						4'd4: r2_q[1] <= prod_q[45:0];
						4'd5: r2_q[2] <= prod_q[45:0];
						default: v2_q <= v2_q + prod_q;
					endcase
					idx_q   <= idx_q + 4'd1;
					state_q <= (idx_q == 4'd8) ? ST_BAND : ST_MUL;
				end
				ST_BAND: begin
					in_sep_q <= !far && d2_q != '0 && d2_q < r2e[0]
						&& cnt_q[BAND_SEP] < CountWidth'(MaxNeighbors);
					in_aln_q <= !far && d2_q > r2e[0] && d2_q < r2e[1]
						&& cnt_q[BAND_ALN] < CountWidth'(MaxNeighbors);
					in_coh_q <= !far && d2_q > r2e[1] && d2_q < r2e[2]
						&& cnt_q[BAND_COH] < CountWidth'(MaxNeighbors);
					comp_q <= '0;
					if (!far && ((d2_q != '0 && d2_q < r2e[0]
							&& cnt_q[BAND_SEP] < CountWidth'(MaxNeighbors))
							|| (d2_q > r2e[1] && d2_q < r2e[2]
							&& cnt_q[BAND_COH] < CountWidth'(MaxNeighbors)))) begin
						vec_sel_q  <= 1'b0;
						sqrt_rad_q <= {2'b00, d2_q};
						sqrt_go_q  <= 1'b1;
						state_q    <= ST_SQRT;
					end else if (!far && d2_q > r2e[0] && d2_q < r2e[1]
							&& cnt_q[BAND_ALN] < CountWidth'(MaxNeighbors)) begin
						vec_sel_q  <= 1'b1;
						sqrt_rad_q <= v2_q;
						sqrt_go_q  <= 1'b1;
						state_q    <= ST_SQRT;
					end else begin
						band_q  <= '0;
						state_q <= last_q ? ST_TMUL : ST_IDLE;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						len_q     <= sqrt_root;
						div_num_q <= {1'b0, unit_mag, 14'd0};
						div_den_q <= sqrt_root;
						div_go_q  <= 1'b1;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						// A zero-length vector normalizes to zero.
						if (len_q == '0)
							u_q[comp_q] <= '0;
						else if (vec_sel_q ? dv_q[comp_q][DiffWidth-1]
								: dp_q[comp_q][DiffWidth-1])
							u_q[comp_q] <= -$signed({1'b0, div_quo[14:0]});
						else
							u_q[comp_q] <= $signed({1'b0, div_quo[14:0]});
						if (comp_q == 2'd2) begin
							state_q <= ST_UPD;
						end else begin
							comp_q    <= comp_nx;
							div_num_q <= {1'b0, unit_mag_nx, 14'd0};
							div_go_q  <= 1'b1;
						end
					end
				end
				ST_UPD: begin
					comp_q <= '0;
					band_q <= '0;
					if (!vec_sel_q) begin
						if (in_sep_q) begin
							for (int j = 0; j < 3; j++)
								sum_q[BAND_SEP][j] <= sum_q[BAND_SEP][j] - SumWidth'(u_q[j]);
							cnt_q[BAND_SEP] <= cnt_q[BAND_SEP] + 1'b1;
						end
						if (in_coh_q) begin
							for (int j = 0; j < 3; j++)
								sum_q[BAND_COH][j] <= sum_q[BAND_COH][j] + SumWidth'(u_q[j]);
							cnt_q[BAND_COH] <= cnt_q[BAND_COH] + 1'b1;
						end
						if (in_aln_q) begin
							vec_sel_q  <= 1'b1;
							sqrt_rad_q <= v2_q;
							sqrt_go_q  <= 1'b1;
							state_q    <= ST_SQRT;
						end else begin
							state_q <= last_q ? ST_TMUL : ST_IDLE;
						end
					end else begin
						for (int j = 0; j < 3; j++)
							sum_q[BAND_ALN][j] <= sum_q[BAND_ALN][j] + SumWidth'(u_q[j]);
						cnt_q[BAND_ALN] <= cnt_q[BAND_ALN] + 1'b1;
						state_q <= last_q ? ST_TMUL : ST_IDLE;
					end
				end
				ST_TMUL: begin
					div_num_q <= prod_w[DivNumWidth-1:0];
					div_den_q <= DivDenWidth'({cnt_q[band_q], 8'd0});
					div_go_q  <= 1'b1;
					state_q   <= ST_TDIV;
				end
				ST_TDIV: begin
					if (div_done) begin
						term_q[band_q][comp_q] <= term_w;
						if (comp_q != 2'd2) begin
							comp_q  <= comp_nx;
							state_q <= ST_TMUL;
						end else if (band_q != BAND_COH) begin
							comp_q  <= '0;
							band_q  <= band_q + 2'd1;
							state_q <= ST_TMUL;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					// The output register frees up when its word is taken.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < 3; i++)
							out_acc_q[i] <= acc_sat[i];
						out_sep_q <= nz;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
